// ===== rtl/lesq_pkg.sv =====
// lesq_pkg: shared widths, types, register indexes and helpers for the
// largest empty square scan. No dependencies.
package lesq_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int SCORE_W   = 11;
  localparam int COORD_W   = 10;
  localparam int CFG_IDX_W = 2;

  typedef logic [SCORE_W-1:0]   score_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_GRID_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_GRID_HEIGHT = cfg_idx_t'(1);

  localparam score_t SCORE_MAX = '1;

  // per-cell position flags handed from the raster counter to the score stage
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_cell;
  } cell_ctl_t;

  function automatic score_t min3(input score_t a, input score_t b, input score_t c);
    score_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

// ===== rtl/lesq_raster.sv =====
// lesq_raster: column and row counters that place each accepted cell in the
// grid and flag the last cell. Depends on lesq_pkg.
module lesq_raster #(
  parameter int MAX_WIDTH  = lesq_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lesq_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  lesq_pkg::score_t                  grid_width,
  input  lesq_pkg::score_t                  grid_height,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]   row,
  output lesq_pkg::cell_ctl_t               ctl
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT + 1);

  logic [ColW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RowW-1:0] row_cnt_r, row_cnt_nxt;
  lesq_pkg::score_t w_eff, h_eff;
  logic wrap, last_col, last_row;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = lesq_pkg::score_t'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = lesq_pkg::score_t'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = lesq_pkg::score_t'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h_eff = lesq_pkg::score_t'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  always_comb begin
    // a column left beyond a narrowed width starts the next row
    wrap = 32'(col_cnt_r) >= 32'(w_eff);
    col  = wrap ? '0 : col_cnt_r;
    row  = wrap ? RowW'(row_cnt_r + 1'b1) : row_cnt_r;

    last_col = (32'(col) + 32'd1) >= 32'(w_eff);
    last_row = (32'(row) + 32'd1) >= 32'(h_eff);

    ctl.first_row = (row == '0);
    ctl.first_col = (col == '0);
    ctl.last_cell = last_col && last_row;

    if (ctl.last_cell) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = RowW'(row + 1'b1);
    end else begin
      col_cnt_nxt = ColW'(col + 1'b1);
      row_cnt_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (advance) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

// ===== rtl/lesq_linebuf.sv =====
// lesq_linebuf: one-row line buffer of scores, registered read with a
// same-address bypass from the write port. Depends on lesq_pkg.
module lesq_linebuf #(
  parameter int MAX_WIDTH = lesq_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output lesq_pkg::score_t              rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  input  lesq_pkg::score_t              wr_data
);

  lesq_pkg::score_t mem [MAX_WIDTH];
  lesq_pkg::score_t rd_q_r;
  lesq_pkg::score_t byp_data_r;
  logic             byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // a write landing on the address being read wins over the old entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

// ===== rtl/lesq_cell.sv =====
// lesq_cell: score stage and result register. Scores the registered cell,
// keeps left/up-left scores and the running best. Depends on lesq_pkg.
module lesq_cell #(
  parameter int MAX_WIDTH  = lesq_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lesq_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  output logic                              take_ready,
  input  logic                              in_obstacle,
  input  logic [$clog2(MAX_WIDTH)-1:0]      in_col,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   in_row,
  input  lesq_pkg::cell_ctl_t               in_ctl,
  input  lesq_pkg::score_t                  up_score,
  output logic                              wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]      wr_addr,
  output lesq_pkg::score_t                  wr_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lesq_pkg::score_t                  out_cell_score,
  output lesq_pkg::score_t                  out_best_size,
  output lesq_pkg::coord_t                  out_best_row,
  output lesq_pkg::coord_t                  out_best_col,
  output logic                              out_grid_done
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT + 1);

  // cell register
  logic                s1_valid_r;
  logic                s1_obst_r;
  logic [ColW-1:0]     s1_col_r;
  logic [RowW-1:0]     s1_row_r;
  lesq_pkg::cell_ctl_t s1_ctl_r;

  // running state
  lesq_pkg::score_t left_r, diag_r, best_r;
  lesq_pkg::coord_t best_row_r, best_col_r;

  // result register
  logic             out_valid_r;
  lesq_pkg::score_t res_score_r, res_best_r;
  lesq_pkg::coord_t res_row_r, res_col_r;
  logic             res_done_r;

  logic             s1_go;
  logic [lesq_pkg::SCORE_W:0] inc;
  lesq_pkg::score_t score, best_nxt;
  lesq_pkg::coord_t row_nxt, col_nxt;
  logic             better;

  assign s1_go      = s1_valid_r && (!out_valid_r || out_ready);
  assign take_ready = !s1_valid_r || s1_go;

  always_comb begin
    inc = {1'b0, lesq_pkg::min3(left_r, up_score, diag_r)} + 1'b1;
    if (s1_obst_r) begin
      score = '0;
    end else if (s1_ctl_r.first_row || s1_ctl_r.first_col) begin
      score = lesq_pkg::score_t'(1);
    end else if (inc[lesq_pkg::SCORE_W]) begin
      score = lesq_pkg::SCORE_MAX;
    end else begin
      score = inc[lesq_pkg::SCORE_W-1:0];
    end
    // strictly larger only, so the earliest cell keeps a tie
    better   = score > best_r;
    best_nxt = better ? score : best_r;
    row_nxt  = better ? lesq_pkg::coord_t'(s1_row_r) : best_row_r;
    col_nxt  = better ? lesq_pkg::coord_t'(s1_col_r) : best_col_r;
  end

  assign wr_en   = s1_go;
  assign wr_addr = s1_col_r;
  assign wr_data = score;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take_ready) begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_obst_r <= in_obstacle;
      s1_col_r  <= in_col;
      s1_row_r  <= in_row;
      s1_ctl_r  <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      diag_r     <= '0;
      best_r     <= '0;
      best_row_r <= '0;
      best_col_r <= '0;
    end else if (s1_go) begin
      if (s1_ctl_r.last_cell) begin
        left_r     <= '0;
        diag_r     <= '0;
        best_r     <= '0;
        best_row_r <= '0;
        best_col_r <= '0;
      end else begin
        left_r     <= score;
        diag_r     <= up_score;
        best_r     <= best_nxt;
        best_row_r <= row_nxt;
        best_col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_score_r <= score;
      res_best_r  <= best_nxt;
      res_row_r   <= row_nxt;
      res_col_r   <= col_nxt;
      res_done_r  <= s1_ctl_r.last_cell;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_score = res_score_r;
  assign out_best_size  = res_best_r;
  assign out_best_row   = res_row_r;
  assign out_best_col   = res_col_r;
  assign out_grid_done  = res_done_r;

endmodule

// ===== rtl/largest_empty_square_scan.sv =====
// Largest empty square scan: takes one cell per clock in raster order and
// returns, for every cell, the side of the largest empty square ending there
// plus the best square so far and its bottom-right corner. A cell is accepted
// every cycle while results are taken; the cell and its line-buffer read are
// registered first, then the score stage fills the result register.
// in_ready follows out_ready combinationally through the score stage. The
// line buffer needs no clearing after reset. The user writes grid_width and
// grid_height only between grids, unenforced by the block. The last cell of
// a grid raises out_grid_done and clears the counters and the best for the
// next grid. Depends on lesq_pkg, lesq_raster, lesq_linebuf and lesq_cell.
module largest_empty_square_scan #(
  parameter int MAX_WIDTH  = lesq_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lesq_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  lesq_pkg::cfg_idx_t cfg_index,
  input  lesq_pkg::score_t   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cell_is_obstacle,
  output logic               out_valid,
  input  logic               out_ready,
  output lesq_pkg::score_t   out_cell_score,
  output lesq_pkg::score_t   out_best_size,
  output lesq_pkg::coord_t   out_best_row,
  output lesq_pkg::coord_t   out_best_col,
  output logic               out_grid_done
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT + 1);

  lesq_pkg::score_t grid_width_r, grid_height_r;
  logic                accept;
  logic [ColW-1:0]     cur_col;
  logic [RowW-1:0]     cur_row;
  lesq_pkg::cell_ctl_t cur_ctl;
  lesq_pkg::score_t    up_score;
  logic                wr_en;
  logic [ColW-1:0]     wr_addr;
  lesq_pkg::score_t    wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lesq_pkg::score_t'(1);
      grid_height_r <= lesq_pkg::score_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lesq_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        lesq_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  lesq_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (accept),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .col         (cur_col),
    .row         (cur_row),
    .ctl         (cur_ctl)
  );

  lesq_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (cur_col),
    .rd_data (up_score),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lesq_cell #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cell (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (accept),
    .take_ready     (in_ready),
    .in_obstacle    (in_cell_is_obstacle),
    .in_col         (cur_col),
    .in_row         (cur_row),
    .in_ctl         (cur_ctl),
    .up_score       (up_score),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_score (out_cell_score),
    .out_best_size  (out_best_size),
    .out_best_row   (out_best_row),
    .out_best_col   (out_best_col),
    .out_grid_done  (out_grid_done)
  );

endmodule

// ===== rtl/lesq_checker.sv =====
// lesq_checker: port-level assertions for largest_empty_square_scan, bound
// to the top level by the bind below. Depends on lesq_pkg.
module lesq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input lesq_pkg::score_t   out_cell_score,
  input lesq_pkg::score_t   out_best_size,
  input lesq_pkg::coord_t   out_best_row,
  input lesq_pkg::coord_t   out_best_col,
  input logic               out_grid_done
);

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_score)
      && $stable(out_best_size) && $stable(out_grid_done))
    else $error("result changed while stalled");

  // the best so far includes the current cell
  a_best_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_size >= out_cell_score)
    else $error("best smaller than cell score");

  // no square yet means the corner is still cleared
  a_no_best_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_best_size == '0 |-> out_best_row == '0 && out_best_col == '0)
    else $error("corner set without a square");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind largest_empty_square_scan lesq_checker u_lesq_checker (.*);

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for largest_empty_square_scan, a directed plan of cells and
// register writes, then grids, checked against hand values or an in-bench square scorer.
// Depends on lesq_pkg and the largest_empty_square_scan rtl.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_W        = lesq_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H        = lesq_pkg::DEF_MAX_HEIGHT;
  localparam int STALL_LIMIT  = 500;
  localparam int RANDOM_CELLS = 450;
  localparam int SETTLE       = 4;
  localparam int MAX_PRINTS   = 40;

  // index with no register behind it, writes to it must change nothing
  localparam lesq_pkg::cfg_idx_t REG_UNUSED = lesq_pkg::cfg_idx_t'(3);

  typedef struct packed {
    lesq_pkg::score_t score;
    lesq_pkg::score_t best;
    lesq_pkg::coord_t row;
    lesq_pkg::coord_t col;
    logic             done;
  } square_t;

  typedef enum logic {STEP_CELL, STEP_REG} step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    lesq_pkg::cfg_idx_t idx;
    lesq_pkg::score_t   val;
    logic               obs;
    logic               known;
    square_t            want;
  } step_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  lesq_pkg::cfg_idx_t cfg_index;
  lesq_pkg::score_t   cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               in_cell_is_obstacle;
  logic               out_valid;
  logic               out_ready;
  lesq_pkg::score_t   out_cell_score;
  lesq_pkg::score_t   out_best_size;
  lesq_pkg::coord_t   out_best_row;
  lesq_pkg::coord_t   out_best_col;
  logic               out_grid_done;

  largest_empty_square_scan dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cell_is_obstacle (in_cell_is_obstacle),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cell_score      (out_cell_score),
    .out_best_size       (out_best_size),
    .out_best_row        (out_best_row),
    .out_best_col        (out_best_col),
    .out_grid_done       (out_grid_done)
  );

  // scorer state, mirrors the block
  lesq_pkg::score_t grid_w_reg = lesq_pkg::score_t'(1);
  lesq_pkg::score_t grid_h_reg = lesq_pkg::score_t'(1);
  int     line_buf [MAX_W];
  int     left_sc, diag_sc, scan_col, scan_row, best_sc, best_r, best_c;

  square_t expected_scores [$];
  int      mismatches;
  bit      quiet_side [2];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // per-request wait, with runs of back-to-back traffic now and then
  function automatic int pick_wait(input int side);
    if ($urandom_range(0, 63) == 0) quiet_side[side] = !quiet_side[side];
    return quiet_side[side] ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic int eff_dim(input lesq_pkg::score_t v, input int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic square_t score_cell(input logic obs);
    int      w, h, col, row, up, sc, m;
    logic    done;
    square_t r;
    w = eff_dim(grid_w_reg, MAX_W);
    h = eff_dim(grid_h_reg, MAX_H);
    // a counter left past a narrowed width wraps to the next row first
    if (scan_col >= w) begin
      scan_col = 0;
      scan_row++;
    end
    col = scan_col;
    row = scan_row;
    up  = line_buf[col];
    if (obs) begin
      sc = 0;
    end else if (row == 0 || col == 0) begin
      sc = 1;
    end else begin
      m = (left_sc < up) ? left_sc : up;
      m = (m < diag_sc) ? m : diag_sc;
      sc = (m >= 2047) ? 2047 : m + 1;
    end
    diag_sc       = up;
    line_buf[col] = sc;
    left_sc       = sc;
    // strictly larger only, so ties keep the earliest cell
    if (sc > best_sc) begin
      best_sc = sc;
      best_r  = row;
      best_c  = col;
    end
    done   = (col + 1 >= w) && (row + 1 >= h);
    r.score = lesq_pkg::score_t'(sc);
    r.best  = lesq_pkg::score_t'(best_sc);
    r.row   = lesq_pkg::coord_t'(best_r);
    r.col   = lesq_pkg::coord_t'(best_c);
    r.done  = done;
    if (done) begin
      scan_col = 0;
      scan_row = 0;
      best_sc  = 0;
      best_r   = 0;
      best_c   = 0;
      left_sc  = 0;
      diag_sc  = 0;
    end else if (col + 1 >= w) begin
      scan_col = 0;
      scan_row = row + 1;
    end else begin
      scan_col = col + 1;
    end
    return r;
  endfunction

  // offer one cell; valid only drops when a gap is drawn
  task automatic send_cell(input logic obs, input logic known, input square_t want);
    int      gap;
    square_t pred;
    gap = pick_wait(0);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_cell_is_obstacle <= obs;
    do @(posedge clk); while (!(in_valid && in_ready));
    pred = score_cell(obs);
    expected_scores.push_back(known ? want : pred);
  endtask

  // registers only change once the pipe has drained
  task automatic write_reg(input lesq_pkg::cfg_idx_t idx, input lesq_pkg::score_t val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == lesq_pkg::REG_GRID_WIDTH) grid_w_reg = val;
    else if (idx == lesq_pkg::REG_GRID_HEIGHT) grid_h_reg = val;
  endtask

  // one setting, a few whole grids; density is obstacles out of 16
  task automatic run_phase(input lesq_pkg::score_t w, input lesq_pkg::score_t h,
                           input bit last_only, input int density, input int grids,
                           output int sent);
    int   cells;
    logic obs;
    write_reg(lesq_pkg::REG_GRID_WIDTH, w);
    write_reg(lesq_pkg::REG_GRID_HEIGHT, h);
    cells = eff_dim(w, MAX_W) * eff_dim(h, MAX_H);
    for (int g = 0; g < grids; g++) begin
      for (int i = 0; i < cells; i++) begin
        obs = last_only ? (i != cells - 1) : ($urandom_range(0, 15) < density);
        send_cell(obs, 1'b0, '0);
      end
    end
    sent = cells * grids;
  endtask

  function automatic step_t cell_row(input logic obs);
    return '{kind: STEP_CELL, idx: '0, val: '0, obs: obs, known: 1'b0, want: '0};
  endfunction

  function automatic step_t known_row(input logic obs, input int sc, input int best,
                                      input int r, input int c, input logic done);
    square_t w;
    w = '{score: lesq_pkg::score_t'(sc), best: lesq_pkg::score_t'(best),
          row: lesq_pkg::coord_t'(r), col: lesq_pkg::coord_t'(c), done: done};
    return '{kind: STEP_CELL, idx: '0, val: '0, obs: obs, known: 1'b1, want: w};
  endfunction

  function automatic step_t reg_row(input lesq_pkg::cfg_idx_t idx, input int val);
    return '{kind: STEP_REG, idx: idx, val: lesq_pkg::score_t'(val), obs: 1'b0,
             known: 1'b0, want: '0};
  endfunction

  // sink side, stalls drawn per result
  initial begin
    int      stall;
    square_t got, want;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = pick_wait(1);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got = '{score: out_cell_score, best: out_best_size, row: out_best_row,
              col: out_best_col, done: out_grid_done};
      if (expected_scores.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, score %0d", got.score));
      end else begin
        want = expected_scores.pop_front();
        if (got.score !== want.score)
          flag_mismatch($sformatf("cell_score %0d, want %0d", got.score, want.score));
        if (got.best !== want.best)
          flag_mismatch($sformatf("best_size %0d, want %0d", got.best, want.best));
        if (got.row !== want.row)
          flag_mismatch($sformatf("best_row %0d, want %0d", got.row, want.row));
        if (got.col !== want.col)
          flag_mismatch($sformatf("best_col %0d, want %0d", got.col, want.col));
        if (got.done !== want.done)
          flag_mismatch($sformatf("grid_done %0b, want %0b", got.done, want.done));
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles with no request moving on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    step_t plan [$];
    int    random_sent, sent, w, h, dens;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_valid            = 1'b0;
    in_cell_is_obstacle = 1'b0;
    mismatches          = 0;
    random_sent         = 0;
    foreach (line_buf[i]) line_buf[i] = 0;
    left_sc  = 0;
    diag_sc  = 0;
    scan_col = 0;
    scan_row = 0;
    best_sc  = 0;
    best_r   = 0;
    best_c   = 0;

    plan = '{
      // reset setting is a one-cell grid
      known_row(1'b0, 1, 1, 0, 0, 1'b1),
      known_row(1'b1, 0, 0, 0, 0, 1'b1),
      known_row(1'b0, 1, 1, 0, 0, 1'b1),
      reg_row(REG_UNUSED, 5),
      known_row(1'b1, 0, 0, 0, 0, 1'b1),
      reg_row(lesq_pkg::REG_GRID_WIDTH, 2), reg_row(lesq_pkg::REG_GRID_HEIGHT, 2),
      cell_row(1'b0), cell_row(1'b0), cell_row(1'b0), cell_row(1'b0),
      // zero sizes act as one
      reg_row(lesq_pkg::REG_GRID_WIDTH, 0), reg_row(lesq_pkg::REG_GRID_HEIGHT, 0),
      known_row(1'b0, 1, 1, 0, 0, 1'b1),
      // ties stay with the earliest cell
      reg_row(lesq_pkg::REG_GRID_WIDTH, 3), reg_row(lesq_pkg::REG_GRID_HEIGHT, 2),
      cell_row(1'b1), cell_row(1'b0), cell_row(1'b0),
      cell_row(1'b0), cell_row(1'b0), cell_row(1'b1),
      // width narrowed part way through a grid
      reg_row(lesq_pkg::REG_GRID_WIDTH, 4), reg_row(lesq_pkg::REG_GRID_HEIGHT, 3),
      cell_row(1'b0), cell_row(1'b0), cell_row(1'b0), cell_row(1'b0),
      cell_row(1'b0), cell_row(1'b0),
      reg_row(lesq_pkg::REG_GRID_WIDTH, 2),
      cell_row(1'b0), cell_row(1'b0),
      // height cut below the current row ends the grid at the row end
      cell_row(1'b0), cell_row(1'b0),
      reg_row(lesq_pkg::REG_GRID_HEIGHT, 1),
      cell_row(1'b0), cell_row(1'b0)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) write_reg(plan[i].idx, plan[i].val);
      else send_cell(plan[i].obs, plan[i].known, plan[i].want);
    end

    // width clamped to the maximum, full-width line buffer, corner in the last column
    run_phase(lesq_pkg::score_t'(2047), lesq_pkg::score_t'(1), 1'b1, 0, 1, sent);
    run_phase(lesq_pkg::score_t'(0), lesq_pkg::score_t'(0), 1'b0, 8, 4, sent);

    while (random_sent < RANDOM_CELLS) begin
      w    = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      h    = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 16) : $urandom_range(1, 12);
      // mostly sparse obstacles so that larger squares form
      dens = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 3);
      run_phase(lesq_pkg::score_t'(w), lesq_pkg::score_t'(h), 1'b0, dens,
                $urandom_range(1, 3), sent);
      random_sent += sent;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
